// File: design/assert_macros.svh
// Assertion macros used by the oscillator back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, disabled while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wto assertion failed");

// Clocked property, checked at every rising clock edge.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wto assertion failed");

`else

`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: design/wto_pkg.sv
// Shared constants, types and width helpers of the wavetable oscillator.
`timescale 1ns / 1ps

package wto_pkg;

  // Default configuration of the wave store and output range
  localparam int TABLE_BITS_DEF  = 11;
  localparam int FRAMES_DEF      = 16;
  localparam int MIP_LEVELS_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Fixed field widths
  localparam int WORD_W = 16;  // table word
  localparam int FRAC_W = 16;  // in-table fraction, Q16
  localparam int MIPF_W = 8;   // mip fraction, Q8
  localparam int FRMF_W = 17;  // frame fraction, Q16 up to 1.0

  // Item kinds carried in tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Register index decoded from paddr[2]
  localparam logic REG_FRAME_COUNT = 1'b0;

  // Queue status seen by producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Bits needed to index n entries, at least one
  function automatic int idx_w(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Width of a store row index (frame and mip together)
  function automatic int row_w(int frames, int mips);
    return idx_w(frames * mips);
  endfunction

  // Width of one queued job
  function automatic int job_w(int tb, int frames, int mips);
    return 1 + row_w(frames, mips) + tb + WORD_W + tb + FRAC_W + idx_w(mips) + MIPF_W
           + 2 * idx_w(frames) + FRMF_W;
  endfunction

endpackage

// File: design/wavetable_oscillator_trilinear_core.sv
// Sample path: a queue pop, eight table reads through the single port of the wave store,
// the arrival of the last word, then the frame and mip blend steps; the back end starts
// no new sample before the result is loaded, and loading waits while the output stalls;
// table writes queue up to four jobs ahead of the back end.
// Reset: phase 0, frame_count 1, queue and result register empty; the wave store
// is not cleared and holds no defined data until written.
`timescale 1ns / 1ps

module wavetable_oscillator_trilinear_core
  import wto_pkg::*;
#(
  parameter int TABLE_BITS  = TABLE_BITS_DEF,
  parameter int FRAMES      = FRAMES_DEF,
  parameter int MIP_LEVELS  = MIP_LEVELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: wr_frame[3:0], wr_mip[6:4], wr_addr[17:7], wr_value[33:18],
  // phase_step[65:34], fm_offset[97:66], mip_level[108:98], scan_pos[125:109], zeros
  input  logic [127:0] s_axis_tdata,
  // tuser: cmd[0]
  input  logic [0:0]   s_axis_tuser,
  // Output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: sample[15:0]
  output logic [15:0]  m_axis_tdata,
  // Configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int JOB_W = job_w(TABLE_BITS, FRAMES, MIP_LEVELS);

  logic [4:0] frame_count_q, frame_count_d;
  logic       cfg_wr;
  logic       push, pop;
  logic [JOB_W-1:0] push_data, head;
  q_stat_t    q_stat;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_COUNT);
  assign frame_count_d = cfg_wr ? pwdata[4:0] : frame_count_q;
  assign prdata = (paddr[2] == REG_FRAME_COUNT) ? {27'b0, frame_count_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= 5'd1;
    end else begin
      frame_count_q <= frame_count_d;
    end
  end

  wto_front #(
    .TABLE_BITS (TABLE_BITS),
    .FRAMES     (FRAMES),
    .MIP_LEVELS (MIP_LEVELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .frame_count_i (frame_count_q),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  wto_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  wto_back #(
    .TABLE_BITS  (TABLE_BITS),
    .FRAMES      (FRAMES),
    .MIP_LEVELS  (MIP_LEVELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: design/wto_queue.sv
// Small register queue between the front and the back of the oscillator.
`timescale 1ns / 1ps

module wto_queue
  import wto_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output q_stat_t          stat_o
);

  localparam int PTR_W = idx_w(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CNT_FULL);
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = slot_q[rptr_q];

  // Advance pointers and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/wto_front.sv
// Front end: accepts stream transactions, tracks phase and prepares jobs.
`timescale 1ns / 1ps

module wto_front
  import wto_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DEF,
  parameter int FRAMES     = FRAMES_DEF,
  parameter int MIP_LEVELS = MIP_LEVELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [127:0]         s_axis_tdata,
  input  logic [0:0]           s_axis_tuser,
  input  logic [4:0]           frame_count_i,
  input  q_stat_t              q_stat_i,
  output logic                 push_o,
  output logic [job_w(TABLE_BITS, FRAMES, MIP_LEVELS)-1:0] push_data_o
);

  localparam int FRM_W = idx_w(FRAMES);
  localparam int MIP_W = idx_w(MIP_LEVELS);
  localparam int ROW_W = row_w(FRAMES, MIP_LEVELS);
  localparam int ADDR_W = ROW_W + TABLE_BITS;
  localparam logic [11:0] MIP_MAX = 12'((MIP_LEVELS - 2) * 256);
  localparam logic [16:0] SCAN_ONE = 17'd65536;

  logic        accept, cmd;
  logic [3:0]  wr_frame;
  logic [2:0]  wr_mip;
  logic [10:0] wr_addr;
  logic [15:0] wr_value;
  logic [31:0] phase_step, fm_offset;
  logic [10:0] mip_level;
  logic [16:0] scan_pos;

  logic [31:0] phase_q, phase_d, phase_fm;
  logic        wr_ok;
  logic [ROW_W-1:0]  wr_row;
  logic [ADDR_W-1:0] waddr;
  logic [TABLE_BITS-1:0] idx;
  logic [FRAC_W-1:0] frac;
  logic [10:0] mip_sat;
  logic [MIP_W-1:0] mip_a;
  logic [MIPF_W-1:0] mip_f;
  logic [4:0]  fc_eff, fc_m1;
  logic        single;
  logic [16:0] scan_c;
  logic [21:0] scan_prod, frac_full;
  logic [5:0]  fa_raw, fa_lim, fa_c;
  logic [FRM_W-1:0] frm_a, frm_b;
  logic [FRMF_W-1:0] frm_f;

  // Unpack the input transaction
  assign cmd        = s_axis_tuser[0];
  assign wr_frame   = s_axis_tdata[3:0];
  assign wr_mip     = s_axis_tdata[6:4];
  assign wr_addr    = s_axis_tdata[17:7];
  assign wr_value   = s_axis_tdata[33:18];
  assign phase_step = s_axis_tdata[65:34];
  assign fm_offset  = s_axis_tdata[97:66];
  assign mip_level  = s_axis_tdata[108:98];
  assign scan_pos   = s_axis_tdata[125:109];

  assign s_axis_tready = !q_stat_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Table write address; drop writes outside the store
  assign wr_ok  = ({5'b0, wr_frame} < 9'(FRAMES)) && ({2'b0, wr_mip} < 5'(MIP_LEVELS));
  assign wr_row = ROW_W'(wr_frame) * ROW_W'(MIP_LEVELS) + ROW_W'(wr_mip);
  assign waddr  = {wr_row, TABLE_BITS'(wr_addr)};

  // Modulated phase splits into table index and fraction
  assign phase_fm = phase_q + fm_offset;
  assign idx      = phase_fm[31 -: TABLE_BITS];
  assign frac     = phase_fm[31-TABLE_BITS -: FRAC_W];

  // Saturate the mip position and split it
  assign mip_sat = ({1'b0, mip_level} > MIP_MAX) ? 11'(MIP_MAX) : mip_level;
  assign mip_a   = MIP_W'(mip_sat[10:8]);
  assign mip_f   = mip_sat[7:0];

  // Frame pair and morph fraction
  always_comb begin
    if (frame_count_i == 5'd0) begin
      fc_eff = 5'd1;
    end else if ({4'b0, frame_count_i} > 9'(FRAMES)) begin
      fc_eff = 5'(FRAMES);
    end else begin
      fc_eff = frame_count_i;
    end
    single    = (fc_eff == 5'd1);
    fc_m1     = fc_eff - 5'd1;
    scan_c    = (scan_pos > SCAN_ONE) ? SCAN_ONE : scan_pos;
    scan_prod = 22'(scan_c) * 22'(fc_m1);
    fa_raw    = scan_prod[21:16];
    fa_lim    = {1'b0, fc_eff - 5'd2};
    fa_c      = (fa_raw > fa_lim) ? fa_lim : fa_raw;
    frac_full = scan_prod - {fa_c, 16'b0};
    if (single) begin
      frm_a = '0;
      frm_b = '0;
      frm_f = '0;
    end else begin
      frm_a = FRM_W'(fa_c);
      frm_b = FRM_W'(fa_c) + 1'b1;
      frm_f = frac_full[FRMF_W-1:0];
    end
  end

  assign push_o      = accept && ((cmd == CMD_SAMPLE) || wr_ok);
  assign push_data_o = {frm_f, frm_b, frm_a, mip_f, mip_a, frac, idx, wr_value, waddr, cmd};

  // Advance the phase after each sample transaction
  assign phase_d = (accept && (cmd == CMD_SAMPLE)) ? phase_q + phase_step : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// File: design/wto_back.sv
// Back end: wave store, eight-read sequencer and the three blend stages.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wto_back
  import wto_pkg::*;
#(
  parameter int TABLE_BITS  = TABLE_BITS_DEF,
  parameter int FRAMES      = FRAMES_DEF,
  parameter int MIP_LEVELS  = MIP_LEVELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [job_w(TABLE_BITS, FRAMES, MIP_LEVELS)-1:0] head_i,
  input  q_stat_t     q_stat_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata
);

  localparam int JOB_W  = job_w(TABLE_BITS, FRAMES, MIP_LEVELS);
  localparam int FRM_W  = idx_w(FRAMES);
  localparam int MIP_W  = idx_w(MIP_LEVELS);
  localparam int ROW_W  = row_w(FRAMES, MIP_LEVELS);
  localparam int ADDR_W = ROW_W + TABLE_BITS;
  localparam int SMP_W  = JOB_W - 1 - ADDR_W - WORD_W;
  localparam int STORE_WORDS = FRAMES * MIP_LEVELS * (2 ** TABLE_BITS);
  localparam logic signed [24:0] SAT_HI = 25'((1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [24:0] SAT_LO = 25'(-(1 <<< (SAMPLE_BITS - 1)));

  // Sequencer states and steps
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [3:0] STEP_ISSUE_LAST = 4'd7;
  localparam logic [3:0] STEP_WORD_LAST  = 4'd8;
  localparam logic [3:0] STEP_FRAME      = 4'd9;
  localparam logic [3:0] STEP_MIX        = 4'd10;

  logic head_cmd;
  logic [ADDR_W-1:0] head_waddr, mem_addr, rd_addr;
  logic [WORD_W-1:0] head_wval;

  logic [SMP_W-1:0] job_q;
  logic [FRMF_W-1:0] frm_f;
  logic [FRM_W-1:0]  frm_a, frm_b, rd_frm;
  logic [MIPF_W-1:0] mip_f;
  logic [MIP_W-1:0]  mip_a, mip_b, rd_mip;
  logic [FRAC_W-1:0] frac;
  logic [TABLE_BITS-1:0] idx, rd_idx;
  logic [ROW_W-1:0]  rd_row;
  logic [2:0] k;

  logic state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic mem_we, load_smp, run_mix;
  logic out_valid_q, out_valid_d;
  logic [15:0] out_data_q;

  logic [15:0] wave_mem [STORE_WORDS];
  logic [15:0] rd_q, wa_q, sa_q, sb_q;
  logic [15:0] t_q [4];
  logic [1:0]  tsel;

  logic signed [16:0] d_t, d_fa, d_fb, d_m;
  logic signed [33:0] p_t;
  logic signed [34:0] p_fa, p_fb;
  logic signed [25:0] p_m;
  logic [17:0] sum_t, mix;
  logic [18:0] sum_fa, sum_fb;
  logic signed [24:0] mix_ext;
  logic [15:0] t_new, res;

  // Split the queue head and the held job
  assign head_cmd   = head_i[0];
  assign head_waddr = head_i[ADDR_W:1];
  assign head_wval  = head_i[ADDR_W+WORD_W:ADDR_W+1];
  assign {frm_f, frm_b, frm_a, mip_f, mip_a, frac, idx} = job_q;

  // Read address for step k: bit 0 next word, bit 1 upper frame, bit 2 upper mip
  assign k       = cnt_q[2:0];
  assign mip_b   = mip_a + 1'b1;
  assign rd_frm  = k[1] ? frm_b : frm_a;
  assign rd_mip  = k[2] ? mip_b : mip_a;
  assign rd_row  = ROW_W'(rd_frm) * ROW_W'(MIP_LEVELS) + ROW_W'(rd_mip);
  assign rd_idx  = idx + TABLE_BITS'(k[0]);
  assign rd_addr = {rd_row, rd_idx};
  assign mem_addr = (state_q == ST_IDLE) ? head_waddr : rd_addr;

  // Sequence one job
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pop_o    = 1'b0;
    load_smp = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          if (head_cmd == CMD_SAMPLE) begin
            state_d = ST_RUN;
            cnt_d   = '0;
          end
        end
      end
      ST_RUN: begin
        if (cnt_q == STEP_MIX) begin
          if (!out_valid_q || m_axis_tready) begin
            load_smp = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign mem_we  = pop_o && (head_cmd == CMD_WRITE);
  assign run_mix = (state_q == ST_RUN) && (cnt_q == STEP_MIX);

  // Result register: hold until taken
  always_comb begin
    if (load_smp) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Wave store, single port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wave_mem[mem_addr] <= head_wval;
    end
    rd_q <= wave_mem[mem_addr];
  end

  // Blend arithmetic: table, frame and mip lerps with floored products
  always_comb begin
    d_t    = $signed({rd_q[15], rd_q}) - $signed({wa_q[15], wa_q});
    p_t    = d_t * $signed({1'b0, frac});
    sum_t  = {{2{wa_q[15]}}, wa_q} + p_t[33:16];
    t_new  = sum_t[15:0];

    d_fa   = $signed({t_q[1][15], t_q[1]}) - $signed({t_q[0][15], t_q[0]});
    p_fa   = d_fa * $signed({1'b0, frm_f});
    sum_fa = {{3{t_q[0][15]}}, t_q[0]} + p_fa[34:16];

    d_fb   = $signed({t_q[3][15], t_q[3]}) - $signed({t_q[2][15], t_q[2]});
    p_fb   = d_fb * $signed({1'b0, frm_f});
    sum_fb = {{3{t_q[2][15]}}, t_q[2]} + p_fb[34:16];

    d_m    = $signed({sb_q[15], sb_q}) - $signed({sa_q[15], sa_q});
    p_m    = d_m * $signed({1'b0, mip_f});
    mix    = {{2{sa_q[15]}}, sa_q} + p_m[25:8];
    mix_ext = $signed({{7{mix[17]}}, mix});

    if (mix_ext > SAT_HI) begin
      res = SAT_HI[15:0];
    end else if (mix_ext < SAT_LO) begin
      res = SAT_LO[15:0];
    end else begin
      res = mix_ext[15:0];
    end
    tsel = 2'(cnt_q[3:1] - 3'd1);
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i[JOB_W-1:JOB_W-SMP_W];
    end
    if ((state_q == ST_RUN) && cnt_q[0] && (cnt_q <= STEP_ISSUE_LAST)) begin
      wa_q <= rd_q;
    end
    if ((state_q == ST_RUN) && !cnt_q[0] && (cnt_q != 4'd0) && (cnt_q <= STEP_WORD_LAST)) begin
      t_q[tsel] <= t_new;
    end
    if ((state_q == ST_RUN) && (cnt_q == STEP_FRAME)) begin
      sa_q <= sum_fa[15:0];
      sb_q <= sum_fb[15:0];
    end
    if (load_smp) begin
      out_data_q <= res;
    end
  end

  // Checks on the sequencer
  `ASSERT_RST(a_no_write_busy, clk_i, rst_ni, (state_q == ST_RUN) |-> !mem_we)
  `ASSERT_RST(a_load_at_mix, clk_i, rst_ni, load_smp |-> run_mix)
  `ASSERT_RST(a_stall_holds, clk_i, rst_ni, (run_mix && out_valid_q && !m_axis_tready) |=> run_mix)
  `ASSERT_RST(a_cnt_range, clk_i, rst_ni, cnt_q <= STEP_MIX)

endmodule

// File: tb/tb_wavetable_oscillator_trilinear_core.sv
// Self-checking testbench of the trilinear wavetable oscillator core.
`timescale 1ns / 1ps

module tb_wavetable_oscillator_trilinear_core
  import wto_pkg::*;
();

  localparam int          STORE_DEPTH = FRAMES_DEF * MIP_LEVELS_DEF * (1 << TABLE_BITS_DEF);
  localparam int          MIP_TOP     = (MIP_LEVELS_DEF - 2) * 256;
  localparam longint      SAMPLE_MAX  = (64'sd1 <<< (SAMPLE_BITS_DEF - 1)) - 1;
  localparam logic [2:0]  FC_ADDR     = {REG_FRAME_COUNT, 2'b00};
  localparam int          DRAIN_WAIT  = 64;
  localparam int          PHASE_ITEMS = 21;

  // Table positions loaded for every frame and mip; reads start at 2047 and wrap to 0
  localparam logic [10:0] LOAD_ADDRS [2] = '{11'd2047, 11'd0};

  typedef struct packed {
    logic        cmd;
    logic [3:0]  wr_frame;
    logic [2:0]  wr_mip;
    logic [10:0] wr_addr;
    logic [15:0] wr_value;
    logic [31:0] phase_step;
    logic [31:0] fm_offset;
    logic [10:0] mip_level;
    logic [16:0] scan_pos;
  } osc_item_t;

  typedef enum logic [1:0] {ROW_WR, ROW_SMP, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [3:0]  frame;
    logic [2:0]  mip;
    logic [10:0] addr;
    logic [15:0] data;      // table word, or frame_count for a register row
    logic [31:0] step;
    logic [31:0] target;    // phase seen by the table read
    logic [10:0] mip_level;
    logic [16:0] scan;
    logic        known;
    logic [15:0] result;
  } dir_row_t;

  localparam int DIR_ROW_N = 23;

  // Directed rows: full-scale words, wrap points, saturations, frame_count edge values
  localparam dir_row_t DIR_ROWS [DIR_ROW_N] = '{
    '{ROW_WR,  4'd0,  3'd0, 11'd0,    16'h7FFF, 32'h0,        32'h0,
      11'd0,    17'd0,      1'b0, 16'h0},
    '{ROW_WR,  4'd0,  3'd0, 11'd1,    16'h8000, 32'h0,        32'h0,
      11'd0,    17'd0,      1'b0, 16'h0},
    '{ROW_WR,  4'd0,  3'd1, 11'd0,    16'h7FFF, 32'h0,        32'h0,
      11'd0,    17'd0,      1'b0, 16'h0},
    '{ROW_WR,  4'd0,  3'd1, 11'd1,    16'h8000, 32'h0,        32'h0,
      11'd0,    17'd0,      1'b0, 16'h0},
    '{ROW_SMP, 4'd0,  3'd0, 11'd0,    16'h0,    32'h0,        32'h0000_0000,
      11'd0,    17'd0,      1'b1, 16'h7FFF},
    '{ROW_SMP, 4'd0,  3'd0, 11'd0,    16'h0,    32'h0,        32'h001F_FFE0,
      11'd0,    17'd0,      1'b1, 16'h8000},
    '{ROW_SMP, 4'd0,  3'd0, 11'd0,    16'h0,    32'h1,        32'h001F_FFE0,
      11'd128,  17'h1FFFF,  1'b1, 16'h8000},
    '{ROW_WR,  4'd15, 3'd7, 11'd2047, 16'hFFFF, 32'h0,        32'h0,
      11'd0,    17'd0,      1'b0, 16'h0},
    '{ROW_SMP, 4'd0,  3'd0, 11'd0,    16'h0,    32'hFFFF_FFFF, 32'hFFFF_FFFF,
      11'd2047, 17'd0,      1'b0, 16'h0},
    '{ROW_SMP, 4'd0,  3'd0, 11'd0,    16'h0,    32'h8000_0000, 32'hFFFF_FFFF,
      11'd1536, 17'd0,      1'b0, 16'h0},
    '{ROW_SMP, 4'd0,  3'd0, 11'd0,    16'h0,    32'h1234_5678, 32'hFFE0_0000,
      11'd255,  17'd0,      1'b0, 16'h0},
    '{ROW_WR,  4'd3,  3'd2, 11'd0,    16'h0000, 32'h0,        32'h0,
      11'd0,    17'd0,      1'b0, 16'h0},
    '{ROW_CFG, 4'd0,  3'd0, 11'd0,    16'd16,   32'h0,        32'h0,
      11'd0,    17'd0,      1'b0, 16'h0},
    '{ROW_SMP, 4'd0,  3'd0, 11'd0,    16'h0,    32'h0,        32'hFFE0_0000,
      11'd0,    17'd65536,  1'b0, 16'h0},
    '{ROW_SMP, 4'd0,  3'd0, 11'd0,    16'h0,    32'h0000_0400, 32'hFFFF_FFE0,
      11'd1536, 17'h1FFFF,  1'b0, 16'h0},
    '{ROW_SMP, 4'd0,  3'd0, 11'd0,    16'h0,    32'h0,        32'hFFF0_0000,
      11'd700,  17'd0,      1'b0, 16'h0},
    '{ROW_CFG, 4'd0,  3'd0, 11'd0,    16'd0,    32'h0,        32'h0,
      11'd0,    17'd0,      1'b0, 16'h0},
    '{ROW_SMP, 4'd0,  3'd0, 11'd0,    16'h0,    32'h0,        32'hFFF0_0010,
      11'd300,  17'd65536,  1'b0, 16'h0},
    '{ROW_CFG, 4'd0,  3'd0, 11'd0,    16'd31,   32'h0,        32'h0,
      11'd0,    17'd0,      1'b0, 16'h0},
    '{ROW_SMP, 4'd0,  3'd0, 11'd0,    16'h0,    32'h0,        32'hFFEF_FFFF,
      11'd1000, 17'd32768,  1'b0, 16'h0},
    '{ROW_CFG, 4'd0,  3'd0, 11'd0,    16'd2,    32'h0,        32'h0,
      11'd0,    17'd0,      1'b0, 16'h0},
    '{ROW_SMP, 4'd0,  3'd0, 11'd0,    16'h0,    32'h0,        32'hFFE1_2345,
      11'd1,    17'd65535,  1'b0, 16'h0},
    '{ROW_SMP, 4'd0,  3'd0, 11'd0,    16'h0,    32'h0,        32'hFFFF_FFFF,
      11'd1535, 17'd1,      1'b0, 16'h0}
  };

  // Frame counts of the random phases; one more is drawn at random
  localparam logic [4:0] PHASE_FC [5] = '{5'd16, 5'd2, 5'd1, 5'd9, 5'd17};

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata  = '0;
  logic [0:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic         psel          = 1'b0;
  logic         penable       = 1'b0;
  logic         pwrite        = 1'b0;
  logic [2:0]   paddr         = '0;
  logic [31:0]  pwdata        = '0;
  logic [31:0]  prdata;
  logic         pready;

  // Shadow of the oscillator state
  shortint      wave_mem [0:STORE_DEPTH-1];
  logic [31:0]  acc_phase = '0;
  logic [4:0]   fc_reg    = 5'd1;
  logic [15:0]  due_samples [$];

  int errors    = 0;
  int n_samples = 0;
  int n_writes  = 0;
  int n_cfg     = 0;
  bit tx_burst  = 1'b0;
  bit rx_burst  = 1'b0;

  wavetable_oscillator_trilinear_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  // Linear blend with floor rounding of the weighted step
  function automatic longint blend(input longint a, input longint b, input longint w,
                                   input int sh);
    return a + (((b - a) * w) >>> sh);
  endfunction

  function automatic longint table_read(input logic [3:0] fr, input logic [2:0] mp,
                                        input logic [10:0] idx, input longint f);
    longint a;
    longint b;
    a = wave_mem[{fr, mp, idx}];
    b = wave_mem[{fr, mp, 11'(idx + 11'd1)}];
    return blend(a, b, f, 16);
  endfunction

  // Compute one output sample and advance the shadow phase
  function automatic logic [15:0] next_sample(input osc_item_t it);
    logic [31:0] p;
    logic [10:0] idx;
    logic [10:0] m;
    logic [2:0]  ma;
    logic [2:0]  mb;
    longint      f;
    longint      mf;
    longint      ff;
    longint      sp;
    longint      scan;
    longint      sa;
    longint      sb;
    longint      s;
    int          fc;
    int          fa;
    p   = acc_phase + it.fm_offset;
    idx = p[31:21];
    f   = p[20:5];
    m   = (it.mip_level > 11'(MIP_TOP)) ? 11'(MIP_TOP) : it.mip_level;
    ma  = m[10:8];
    mb  = ma + 3'd1;
    mf  = m[7:0];
    fc  = fc_reg;
    if (fc < 1) fc = 1;
    if (fc > FRAMES_DEF) fc = FRAMES_DEF;
    if (fc == 1) begin
      sa = table_read(4'd0, ma, idx, f);
      sb = table_read(4'd0, mb, idx, f);
    end else begin
      scan = it.scan_pos;
      if (scan > 65536) scan = 65536;
      sp = scan * longint'(fc - 1);
      fa = int'(sp >>> 16);
      if (fa > fc - 2) fa = fc - 2;
      ff = sp - longint'(fa) * 65536;
      sa = blend(table_read(4'(fa), ma, idx, f), table_read(4'(fa + 1), ma, idx, f), ff, 16);
      sb = blend(table_read(4'(fa), mb, idx, f), table_read(4'(fa + 1), mb, idx, f), ff, 16);
    end
    s = blend(sa, sb, mf, 8);
    if (s > SAMPLE_MAX) s = SAMPLE_MAX;
    if (s < -SAMPLE_MAX - 1) s = -SAMPLE_MAX - 1;
    acc_phase = acc_phase + it.phase_step;
    return 16'(s);
  endfunction

  // Random content everywhere; callers overwrite the fields that matter
  function automatic osc_item_t noise_item();
    osc_item_t it;
    it.cmd        = 1'($urandom);
    it.wr_frame   = 4'($urandom);
    it.wr_mip     = 3'($urandom);
    it.wr_addr    = 11'($urandom);
    it.wr_value   = 16'($urandom);
    it.phase_step = $urandom;
    it.fm_offset  = $urandom;
    it.mip_level  = 11'($urandom);
    it.scan_pos   = 17'($urandom);
    return it;
  endfunction

  function automatic osc_item_t make_write(input logic [3:0] fr, input logic [2:0] mp,
                                           input logic [10:0] ad, input logic [15:0] val);
    osc_item_t it;
    it          = noise_item();
    it.cmd      = CMD_WRITE;
    it.wr_frame = fr;
    it.wr_mip   = mp;
    it.wr_addr  = ad;
    it.wr_value = val;
    return it;
  endfunction

  // Offset the FM input so that the read lands on the target phase
  function automatic osc_item_t make_sample(input logic [31:0] step, input logic [31:0] target,
                                            input logic [10:0] ml, input logic [16:0] scan);
    osc_item_t it;
    it            = noise_item();
    it.cmd        = CMD_SAMPLE;
    it.phase_step = step;
    it.fm_offset  = target - acc_phase;
    it.mip_level  = ml;
    it.scan_pos   = scan;
    return it;
  endfunction

  // Present one transaction, then update the shadow state on acceptance
  task automatic send_item(input osc_item_t it, input bit known, input logic [15:0] typed);
    int          gap;
    logic [15:0] pred;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {2'b00, it.scan_pos, it.mip_level, it.fm_offset, it.phase_step,
                      it.wr_value, it.wr_addr, it.wr_mip, it.wr_frame};
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.cmd == CMD_WRITE) begin
      wave_mem[{it.wr_frame, it.wr_mip, it.wr_addr}] = shortint'(it.wr_value);
      n_writes++;
    end else begin
      pred = next_sample(it);
      due_samples.push_back(known ? typed : pred);
    end
  endtask

  // Let the block go idle, write frame_count through the register port, read it back
  task automatic write_frame_count(input logic [4:0] val);
    s_axis_tvalid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FC_ADDR;
    pwdata  <= {27'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[4:0] !== val) begin
      $error("frame_count: expected %h, actual %h", val, prdata[4:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    fc_reg = val;
    n_cfg++;
  endtask

  // One random item: mostly well-aimed samples, some table rewrites and stray writes
  task automatic send_random();
    logic [31:0] target;
    logic [31:0] step;
    logic [10:0] ml;
    logic [16:0] scan;
    logic [15:0] val;
    int          pick;
    pick = $urandom_range(0, 9);
    val  = 16'($urandom);
    if ($urandom_range(0, 7) == 0) val = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    if (pick < 2) begin
      send_item(make_write(4'($urandom), 3'($urandom), LOAD_ADDRS[$urandom_range(0, 1)], val),
                1'b0, '0);
    end else if (pick == 2) begin
      send_item(make_write(4'($urandom), 3'($urandom), 11'($urandom), val), 1'b0, '0);
    end else begin
      target = {11'd2047, 21'($urandom)};
      case ($urandom_range(0, 7))
        0: target[20:5] = '0;
        1: target[20:5] = '1;
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0: step = '0;
        1: step = '1;
        default: step = $urandom;
      endcase
      ml = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(MIP_TOP + 1, 2047))
                                       : 11'($urandom_range(0, MIP_TOP));
      case ($urandom_range(0, 9))
        0: scan = 17'($urandom_range(65537, 131071));
        1: scan = 17'd65536;
        2: scan = 17'd0;
        default: scan = 17'($urandom_range(0, 65536));
      endcase
      send_item(make_sample(step, target, ml, scan), 1'b0, '0);
    end
  endtask

  // Result side: random stalls, compare each sample with the oldest expectation
  initial begin
    int          gap;
    logic [15:0] want;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (due_samples.size() == 0) begin
        $error("sample: expected none, actual %h", m_axis_tdata);
        errors++;
      end else begin
        want = due_samples.pop_front();
        n_samples++;
        if (m_axis_tdata !== want) begin
          $error("sample: expected %h, actual %h", want, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    dir_row_t   row;
    logic [4:0] fc_val;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every frame and mip at the positions that samples read
    for (int fr = 0; fr < FRAMES_DEF; fr++) begin
      for (int mp = 0; mp < MIP_LEVELS_DEF; mp++) begin
        for (int a = 0; a < 2; a++) begin
          send_item(make_write(4'(fr), 3'(mp), LOAD_ADDRS[a], 16'($urandom)), 1'b0, '0);
        end
      end
    end

    // Directed rows
    for (int i = 0; i < DIR_ROW_N; i++) begin
      row = DIR_ROWS[i];
      case (row.kind)
        ROW_WR: begin
          send_item(make_write(row.frame, row.mip, row.addr, row.data), 1'b0, '0);
        end
        ROW_SMP: begin
          send_item(make_sample(row.step, row.target, row.mip_level, row.scan),
                    row.known, row.result);
        end
        default: begin
          write_frame_count(row.data[4:0]);
        end
      endcase
    end

    // Random phases, each under its own frame_count
    for (int ph = 0; ph < 6; ph++) begin
      fc_val = (ph < 5) ? PHASE_FC[ph] : 5'($urandom_range(3, 15));
      write_frame_count(fc_val);
      repeat (PHASE_ITEMS) send_random();
    end

    // Drain
    s_axis_tvalid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d samples and %0d table writes under %0d frame_count settings,",
             n_samples, n_writes, n_cfg);
    $display("with saturated mip and scan inputs, index wrap and random stalls on both sides.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
